FILE: hw/rtl/hlpd_pkg.sv
`default_nettype none

package hlpd_pkg;

    // default sizes of the raster
    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 1024;

    // field widths on the channels
    localparam int HEIGHT_W   = 4;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 7;
    localparam int RISK_W     = 24;
    localparam int COUNT_W    = 17;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int COLS_REG_W = 8;
    localparam int ROWS_REG_W = 11;

    // frame size after reset
    localparam int FRAME_RESET = 100;

    // result bundle queue
    localparam int BQ_DEPTH = 4;
    localparam int BQ_PTR_W = $clog2(BQ_DEPTH);
    localparam int BQ_CNT_W = $clog2(BQ_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = CFG_IDX_W'(1);

    // candidates decided by one incoming word, in output order
    typedef struct packed {
        logic                up_hit;
        logic                left_hit;
        logic                final_hit;
        logic                summary;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [HEIGHT_W-1:0] up_h;
        logic [HEIGHT_W-1:0] left_h;
        logic [HEIGHT_W-1:0] final_h;
    } hlpd_bundle_t;

    // last index of a dimension, size held within 2..limit
    function automatic logic [31:0] last_index(input logic [31:0] value,
                                               input logic [31:0] limit);
        logic [31:0] res;
        if (value < 32'd2)
            res = 32'd1;
        else if (value > limit)
            res = limit - 32'd1;
        else
            res = value - 32'd1;
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hlpd_cell_if.sv
`default_nettype none

interface hlpd_cell_if
    import hlpd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] height;

    modport source (output valid, output height, input ready);
    modport sink (input valid, input height, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hlpd_result_if.sv
`default_nettype none

interface hlpd_result_if
    import hlpd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                is_summary;
    logic [ROW_W-1:0]    point_row;
    logic [COL_W-1:0]    point_col;
    logic [HEIGHT_W-1:0] point_height;
    logic [RISK_W-1:0]   risk_total;
    logic [COUNT_W-1:0]  low_count;
    logic                last;

    modport source (output valid, output is_summary, output point_row, output point_col,
                    output point_height, output risk_total, output low_count, output last,
                    input ready);
    modport sink (input valid, input is_summary, input point_row, input point_col,
                  input point_height, input risk_total, input low_count, input last,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hlpd_cfg_if.sv
`default_nettype none

interface hlpd_cfg_if
    import hlpd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hlpd_line_store.sv
`default_nettype none

module hlpd_line_store
    import hlpd_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_COLS,
    parameter int WIDTH = 2 * HEIGHT_W
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr0,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr1,
    output logic [WIDTH-1:0]              rd_data0,
    output logic [WIDTH-1:0]              rd_data1,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd0_reg;
    logic [WIDTH-1:0] rd1_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // two read ports, a write in the same cycle is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd0_reg <= (wr_en && (wr_addr == rd_addr0)) ? wr_data : mem[rd_addr0];
            rd1_reg <= (wr_en && (wr_addr == rd_addr1)) ? wr_data : mem[rd_addr1];
        end
    end

    assign rd_data0 = rd0_reg;
    assign rd_data1 = rd1_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/hlpd_detect.sv
`default_nettype none

module hlpd_detect
    import hlpd_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        restart,
    input  wire logic [$clog2(MAX_COLS)-1:0] cols_m1,
    input  wire logic [$clog2(MAX_ROWS)-1:0] rows_m1,
    input  wire logic                        room,
    hlpd_cell_if.sink                        heights,
    output logic                             busy,
    output logic                             bundle_valid,
    output hlpd_bundle_t                     bundle
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int EW = 2 * HEIGHT_W;

    logic          accept;
    logic          at_last_col;
    logic          at_last_row;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    // second stage, registered in the cycle after a word is accepted
    logic                s1_valid_reg;
    logic [HEIGHT_W-1:0] s1_h_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [RW-1:0]       s1_row_reg;
    logic                s1_last_col_reg;
    logic                s1_last_row_reg;

    // neighbours carried along the row
    logic [HEIGHT_W-1:0] left_reg;
    logic [HEIGHT_W-1:0] cell1_reg;
    logic [HEIGHT_W-1:0] cell2_reg;

    logic [EW-1:0]       rd_here;
    logic [EW-1:0]       rd_right;
    logic [HEIGHT_W-1:0] prev_c;
    logic [HEIGHT_W-1:0] older_c;
    logic [HEIGHT_W-1:0] prev_c1;
    logic                up_hit;
    logic                left_hit;
    logic                final_hit;
    logic                summary;

    // input handshake
    assign heights.ready = room;
    assign accept        = heights.valid && room;
    assign at_last_col   = (col_reg == cols_m1);
    assign at_last_row   = (row_reg == rows_m1);

    // raster position of the next word
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (at_last_col)
            begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
        end
    end

    // capture of the accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_h_reg        <= heights.height;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_last_col_reg <= at_last_col;
            s1_last_row_reg <= at_last_row;
        end
    end

    // entry holds {row two above, row above}
    hlpd_line_store #(
        .DEPTH (MAX_COLS),
        .WIDTH (EW)
    ) u_line_store (
        .clk      (clk),
        .rd_en    (accept),
        .rd_addr0 (col_reg),
        .rd_addr1 (col_reg + CW'(1)),
        .rd_data0 (rd_here),
        .rd_data1 (rd_right),
        .wr_en    (s1_valid_reg),
        .wr_addr  (s1_col_reg),
        .wr_data  ({rd_here[HEIGHT_W-1:0], s1_h_reg})
    );

    assign prev_c  = rd_here[HEIGHT_W-1:0];
    assign older_c = rd_here[EW-1:HEIGHT_W];
    assign prev_c1 = rd_right[HEIGHT_W-1:0];

    // row neighbours for the next column
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            left_reg  <= prev_c;
            cell1_reg <= s1_h_reg;
            cell2_reg <= cell1_reg;
        end
    end

    // cell above, now that its lower neighbour is here
    assign up_hit = (s1_row_reg != '0) && (prev_c < s1_h_reg)
                 && ((s1_row_reg <= RW'(1)) || (prev_c < older_c))
                 && ((s1_col_reg == '0) || (prev_c < left_reg))
                 && (s1_last_col_reg || (prev_c < prev_c1));

    // bottom-row cell to the left, now that its right neighbour is here
    assign left_hit = s1_last_row_reg && (s1_col_reg != '0)
                   && (cell1_reg < s1_h_reg) && (cell1_reg < left_reg)
                   && ((s1_col_reg <= CW'(1)) || (cell1_reg < cell2_reg));

    // final cell of the frame has no right or lower neighbour
    assign final_hit = s1_last_row_reg && s1_last_col_reg
                    && (s1_h_reg < prev_c) && (s1_h_reg < cell1_reg);

    assign summary = s1_last_row_reg && s1_last_col_reg;

    always_comb
    begin
        bundle.up_hit    = up_hit;
        bundle.left_hit  = left_hit;
        bundle.final_hit = final_hit;
        bundle.summary   = summary;
        bundle.row       = ROW_W'(s1_row_reg);
        bundle.col       = COL_W'(s1_col_reg);
        bundle.up_h      = prev_c;
        bundle.left_h    = cell1_reg;
        bundle.final_h   = s1_h_reg;
    end

    assign bundle_valid = s1_valid_reg && (up_hit || left_hit || final_hit || summary);
    assign busy         = s1_valid_reg;

    // position never runs past the frame
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= cols_m1)
        else $error("column position past last column");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= rows_m1)
        else $error("row position past last row");

    // the word closing a frame leaves the position at the origin
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && summary |-> (col_reg == '0) && (row_reg == '0))
        else $error("frame end without position wrap");

endmodule

`default_nettype wire

FILE: hw/rtl/hlpd_emit.sv
`default_nettype none

module hlpd_emit
    import hlpd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          restart,
    input  wire logic          push,
    input  wire hlpd_bundle_t  bundle,
    input  wire logic          inflight,
    output logic               room,
    hlpd_result_if.source      results
);

    typedef enum logic [1:0] {
        SEL_UP,
        SEL_LEFT,
        SEL_FINAL,
        SEL_SUMMARY
    } hlpd_sel_t;

    localparam int CW1 = BQ_CNT_W + 1;

    hlpd_bundle_t        bq_mem [BQ_DEPTH];
    logic [BQ_PTR_W-1:0] wr_ptr_reg;
    logic [BQ_PTR_W-1:0] rd_ptr_reg;
    logic [BQ_CNT_W-1:0] count_reg;
    logic [BQ_CNT_W-1:0] count_next;
    logic [3:0]          done_reg;
    logic [3:0]          done_next;
    logic [RISK_W-1:0]   risk_reg;
    logic [RISK_W-1:0]   risk_next;
    logic [COUNT_W-1:0]  lows_reg;
    logic [COUNT_W-1:0]  lows_next;

    hlpd_bundle_t        head;
    logic [3:0]          pending;
    logic [3:0]          sel_bit;
    hlpd_sel_t           sel;
    logic [HEIGHT_W-1:0] sel_h;
    logic [ROW_W-1:0]    sel_row;
    logic [COL_W-1:0]    sel_col;
    logic [RISK_W:0]     risk_sum;
    logic [RISK_W-1:0]   risk_sat;
    logic [COUNT_W-1:0]  lows_inc;
    logic                fire;
    logic                is_last;
    logic                pop;

    // space for the word in flight and one more
    assign room = (CW1'(count_reg) + CW1'(inflight)) < CW1'(BQ_DEPTH);

    // bundle queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            bq_mem[wr_ptr_reg] <= bundle;
        end
    end

    assign head    = bq_mem[rd_ptr_reg];
    assign pending = {head.summary, head.final_hit, head.left_hit, head.up_hit} & ~done_reg;

    // next result of the head bundle, in raster order with the summary last
    always_comb
    begin
        sel     = SEL_SUMMARY;
        sel_bit = 4'b1000;
        priority if (pending[0])
        begin
            sel     = SEL_UP;
            sel_bit = 4'b0001;
        end
        else if (pending[1])
        begin
            sel     = SEL_LEFT;
            sel_bit = 4'b0010;
        end
        else if (pending[2])
        begin
            sel     = SEL_FINAL;
            sel_bit = 4'b0100;
        end
    end

    always_comb
    begin
        unique case (sel)
            SEL_UP:
            begin
                sel_h   = head.up_h;
                sel_row = head.row - ROW_W'(1);
                sel_col = head.col;
            end
            SEL_LEFT:
            begin
                sel_h   = head.left_h;
                sel_row = head.row;
                sel_col = head.col - COL_W'(1);
            end
            SEL_FINAL:
            begin
                sel_h   = head.final_h;
                sel_row = head.row;
                sel_col = head.col;
            end
            default:
            begin
                sel_h   = '0;
                sel_row = '0;
                sel_col = '0;
            end
        endcase
    end

    // saturating totals including the shown point
    assign risk_sum = {1'b0, risk_reg} + (RISK_W + 1)'(sel_h) + (RISK_W + 1)'(1);
    assign risk_sat = risk_sum[RISK_W] ? '1 : risk_sum[RISK_W-1:0];
    assign lows_inc = (lows_reg == '1) ? lows_reg : lows_reg + COUNT_W'(1);

    // output word
    assign results.valid        = (count_reg != '0);
    assign results.is_summary   = (sel == SEL_SUMMARY);
    assign results.point_row    = sel_row;
    assign results.point_col    = sel_col;
    assign results.point_height = sel_h;
    assign results.risk_total   = (sel == SEL_SUMMARY) ? risk_reg : risk_sat;
    assign results.low_count    = (sel == SEL_SUMMARY) ? lows_reg : lows_inc;
    assign results.last         = ((pending & ~sel_bit) == 4'b0000);

    assign fire    = results.valid && results.ready;
    assign is_last = results.last;
    assign pop     = fire && is_last;

    // queue fill and progress through the head bundle
    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + BQ_CNT_W'(1);
            2'b01:   count_next = count_reg - BQ_CNT_W'(1);
            default: count_next = count_reg;
        endcase

        done_next = done_reg;
        if (pop)
            done_next = 4'b0000;
        else if (fire)
            done_next = done_reg | sel_bit;

        risk_next = risk_reg;
        lows_next = lows_reg;
        if (restart)
        begin
            risk_next = '0;
            lows_next = '0;
        end
        else if (fire)
        begin
            if (sel == SEL_SUMMARY)
            begin
                risk_next = '0;
                lows_next = '0;
            end
            else
            begin
                risk_next = risk_sat;
                lows_next = lows_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            done_reg   <= 4'b0000;
            risk_reg   <= '0;
            lows_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + BQ_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + BQ_PTR_W'(1);
            count_reg <= count_next;
            done_reg  <= done_next;
            risk_reg  <= risk_next;
            lows_reg  <= lows_next;
        end
    end

    // queue never overflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < BQ_CNT_W'(BQ_DEPTH)) || pop)
        else $error("bundle queue overflow");

    // a summary is always the final word of its bundle
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.is_summary |-> results.last)
        else $error("summary word not marked last");

    // a queued bundle always has something to show
    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (pending != 4'b0000))
        else $error("empty bundle at queue head");

endmodule

`default_nettype wire

FILE: hw/rtl/height_map_low_point_detector_top.sv
// channel   dir  fields                                        handshake
// heights   in   height[3:0]                                   valid / ready
// results   out  is_summary, point_row, point_col,             valid / ready
//                point_height, risk_total, low_count, last
// cfg       in   index[3:0], data[15:0]                        valid / ready (always ready)
//
// one height word is taken every cycle while there is room; its results pass the second stage
// up to four result words per height word leave the 4-deep bundle queue one per ready cycle,
// so input stalls only while the queue has no room for the word in flight and one more
// line stores are a single dual-read memory of MAX_COLS entries, read ahead at the column
// and the one to its right, with same-cycle writes forwarded; no clearing pass after reset
// rst_n clears positions, totals and queue; a write to a size register restarts the frame

`default_nettype none

module height_map_low_point_detector_top
    import hlpd_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    hlpd_cell_if.sink      heights,
    hlpd_result_if.source  results,
    hlpd_cfg_if.sink       cfg
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam logic [CW-1:0] COLS_M1_RST = CW'(last_index(32'(FRAME_RESET), 32'(MAX_COLS)));
    localparam logic [RW-1:0] ROWS_M1_RST = RW'(last_index(32'(FRAME_RESET), 32'(MAX_ROWS)));

    logic [CW-1:0] cols_m1_reg;
    logic [CW-1:0] cols_m1_next;
    logic [RW-1:0] rows_m1_reg;
    logic [RW-1:0] rows_m1_next;
    logic          restart;
    logic          room;
    logic          busy;
    logic          bundle_valid;
    hlpd_bundle_t  bundle;

    // register writes, held within the supported frame size
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cols_m1_next = cols_m1_reg;
        rows_m1_next = rows_m1_reg;
        restart      = 1'b0;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FRAME_COLS:
                begin
                    cols_m1_next = CW'(last_index(32'(cfg.data[COLS_REG_W-1:0]),
                                                  32'(MAX_COLS)));
                    restart      = 1'b1;
                end
                REG_FRAME_ROWS:
                begin
                    rows_m1_next = RW'(last_index(32'(cfg.data[ROWS_REG_W-1:0]),
                                                  32'(MAX_ROWS)));
                    restart      = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_m1_reg <= COLS_M1_RST;
            rows_m1_reg <= ROWS_M1_RST;
        end
        else
        begin
            cols_m1_reg <= cols_m1_next;
            rows_m1_reg <= rows_m1_next;
        end
    end

    // line stores and neighbour tests
    hlpd_detect #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_detect (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .cols_m1      (cols_m1_reg),
        .rows_m1      (rows_m1_reg),
        .room         (room),
        .heights      (heights),
        .busy         (busy),
        .bundle_valid (bundle_valid),
        .bundle       (bundle)
    );

    // result queue and running totals
    hlpd_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (restart),
        .push     (bundle_valid),
        .bundle   (bundle),
        .inflight (busy),
        .room     (room),
        .results  (results)
    );

endmodule

`default_nettype wire

FILE: tb/sv/height_map_low_point_detector_top_tb.sv
`timescale 1ns / 100ps

module height_map_low_point_detector_top_tb;
    import hlpd_pkg::*;

    localparam int N_COLS        = DEF_MAX_COLS;
    localparam int N_ROWS        = DEF_MAX_ROWS;
    localparam int RISK_LIMIT    = (1 << RISK_W) - 1;
    localparam int COUNT_LIMIT   = (1 << COUNT_W) - 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 90;
    localparam int BURST_CELLS   = 64;
    localparam int TALL_CELLS    = 40;
    localparam int TIMEOUT_NS    = 4000000;

    // one result word as seen on the output channel
    typedef struct packed {
        logic                is_summary;
        logic [ROW_W-1:0]    point_row;
        logic [COL_W-1:0]    point_col;
        logic [HEIGHT_W-1:0] point_height;
        logic [RISK_W-1:0]   risk_total;
        logic [COUNT_W-1:0]  low_count;
        logic                last;
    } point_word_t;

    // shapes of random height content
    typedef enum int {PAT_UNIFORM, PAT_NARROW, PAT_CHECKER, PAT_EXTREME} height_pattern_t;

    // low point predictor and store of expected words
    class low_point_scoreboard;
        logic [COLS_REG_W-1:0] cols_reg;
        logic [ROWS_REG_W-1:0] rows_reg;
        logic [HEIGHT_W-1:0]   two_up_row [N_COLS];
        logic [HEIGHT_W-1:0]   one_up_row [N_COLS];
        logic [HEIGHT_W-1:0]   row_tail [3];
        int                    next_col;
        int                    next_row;
        int                    risk_sum;
        int                    point_count;
        int                    mismatches;
        point_word_t           expected_points [$];

        function new();
            cols_reg = COLS_REG_W'(FRAME_RESET);
            rows_reg = ROWS_REG_W'(FRAME_RESET);
            for (int i = 0; i < N_COLS; i++)
            begin
                two_up_row[i] = '0;
                one_up_row[i] = '0;
            end
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            next_col = 0;
            next_row = 0;
            for (int i = 0; i < 3; i++)
                row_tail[i] = '0;
            risk_sum = 0;
            point_count = 0;
        endfunction

        function int clamp_size(int v, int lo, int hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void frame_shape(output int cols, output int rows);
            cols = clamp_size(int'(cols_reg), 2, N_COLS);
            rows = clamp_size(int'(rows_reg), 2, N_ROWS);
        endfunction

        function int points_outstanding();
            return expected_points.size();
        endfunction

        function void push_word(logic is_sum, int r, int c, logic [HEIGHT_W-1:0] h);
            point_word_t w;
            w.is_summary   = is_sum;
            w.point_row    = ROW_W'(r);
            w.point_col    = COL_W'(c);
            w.point_height = h;
            w.risk_total   = RISK_W'(risk_sum);
            w.low_count    = COUNT_W'(point_count);
            w.last         = 1'b0;
            expected_points.insert(expected_points.size(), w);
        endfunction

        function void add_low_point(int r, int c, logic [HEIGHT_W-1:0] h);
            risk_sum = risk_sum + int'(h) + 1;
            if (risk_sum > RISK_LIMIT) risk_sum = RISK_LIMIT;
            if (point_count < COUNT_LIMIT) point_count++;
            push_word(1'b0, r, c, h);
        endfunction

        // register write: only the two size registers restart the frame
        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_FRAME_COLS)
            begin
                cols_reg = value[COLS_REG_W-1:0];
                clear_frame();
            end
            else if (idx == REG_FRAME_ROWS)
            begin
                rows_reg = value[ROWS_REG_W-1:0];
                clear_frame();
            end
        endfunction

        // decide the cells that one incoming height completes
        function void predict_cell(logic [HEIGHT_W-1:0] h);
            int                  cols;
            int                  rows;
            int                  c;
            int                  r;
            int                  first;
            bit                  on_last_row;
            bit                  on_last_col;
            bit                  ok;
            logic [HEIGHT_W-1:0] ctr;
            frame_shape(cols, rows);
            c = next_col;
            r = next_row;
            on_last_row = (r == rows - 1);
            on_last_col = (c == cols - 1);
            if (c >= cols) c = cols - 1;
            if (r >= rows) r = rows - 1;
            first = expected_points.size();

            // cell above now has its lower neighbour
            if (r >= 1)
            begin
                ctr = one_up_row[c];
                ok = (ctr < h);
                if (r >= 2 && !(ctr < two_up_row[c])) ok = 0;
                if (c >= 1 && !(ctr < two_up_row[c - 1])) ok = 0;
                if (c + 1 < cols && !(ctr < one_up_row[c + 1])) ok = 0;
                if (ok) add_low_point(r - 1, c, ctr);
                two_up_row[c] = one_up_row[c];
            end
            one_up_row[c] = h;
            row_tail[2] = row_tail[1];
            row_tail[1] = row_tail[0];
            row_tail[0] = h;

            // bottom row: left cell now has its right neighbour, final cell at once
            if (on_last_row)
            begin
                if (c >= 1)
                begin
                    ctr = row_tail[1];
                    ok = (ctr < row_tail[0]) && (ctr < two_up_row[c - 1]);
                    if (c >= 2 && !(ctr < row_tail[2])) ok = 0;
                    if (ok) add_low_point(r, c - 1, ctr);
                end
                if (on_last_col && row_tail[0] < two_up_row[c] && row_tail[0] < row_tail[1])
                    add_low_point(r, c, row_tail[0]);
            end

            // advance position, summary word closes the frame
            if (on_last_col)
            begin
                next_col = 0;
                if (on_last_row)
                begin
                    push_word(1'b1, 0, 0, '0);
                    clear_frame();
                end
                else
                    next_row = r + 1;
            end
            else
            begin
                next_col = c + 1;
                next_row = r;
            end
            if (expected_points.size() > first)
                expected_points[expected_points.size() - 1].last = 1'b1;
        endfunction

        function int field_differs(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                return 1;
            end
            return 0;
        endfunction

        // compare an output word with the oldest expectation
        function void check_point(point_word_t got);
            point_word_t want;
            if (expected_points.size() == 0)
            begin
                $error("result word with no point pending: row %0d col %0d summary %0d",
                       got.point_row, got.point_col, got.is_summary);
                mismatches++;
                return;
            end
            want = expected_points.pop_front();
            mismatches += field_differs("is_summary", 32'(want.is_summary), 32'(got.is_summary));
            mismatches += field_differs("point_row", 32'(want.point_row), 32'(got.point_row));
            mismatches += field_differs("point_col", 32'(want.point_col), 32'(got.point_col));
            mismatches += field_differs("point_height", 32'(want.point_height),
                                        32'(got.point_height));
            mismatches += field_differs("risk_total", 32'(want.risk_total), 32'(got.risk_total));
            mismatches += field_differs("low_count", 32'(want.low_count), 32'(got.low_count));
            mismatches += field_differs("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   src_idle_pct;
    int   snk_idle_pct;

    low_point_scoreboard points_sb = new();

    hlpd_cell_if   heights_ch ();
    hlpd_result_if results_ch ();
    hlpd_cfg_if    cfg_ch ();

    height_map_low_point_detector_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .heights (heights_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver back-pressure
    initial
    begin
        results_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results_ch.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        point_word_t got;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            got.is_summary   = results_ch.is_summary;
            got.point_row    = results_ch.point_row;
            got.point_col    = results_ch.point_col;
            got.point_height = results_ch.point_height;
            got.risk_total   = results_ch.risk_total;
            got.low_count    = results_ch.low_count;
            got.last         = results_ch.last;
            points_sb.check_point(got);
        end
    end

    // watchdog
    initial
    begin
        #TIMEOUT_NS;
        $display("height_map_low_point_detector_top test failed");
        $finish;
    end

    task automatic send_height(input logic [HEIGHT_W-1:0] h);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            heights_ch.valid = 1'b0;
            @(negedge clk);
        end
        heights_ch.valid  = 1'b1;
        heights_ch.height = h;
        do
            @(posedge clk);
        while (!heights_ch.ready);
        points_sb.predict_cell(h);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        points_sb.apply_register(idx, value);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // stop sending and let every pending point come out, plus pipeline slack
    task automatic drain_points();
        @(negedge clk);
        heights_ch.valid = 1'b0;
        while (points_sb.points_outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // directed cells given as hex digits, leftmost first
    task automatic send_height_digits(input logic [63:0] cells, input int n);
        for (int i = 0; i < n; i++)
            send_height(cells[HEIGHT_W * (n - 1 - i) +: HEIGHT_W]);
    endtask

    // random cells of one shape, with an optional full drain part way through
    task automatic send_cells(input int n_cells, input int cols, input height_pattern_t pattern,
                              input int pause_at);
        logic [HEIGHT_W-1:0] h;
        int                  base;
        base = int'($urandom_range(13));
        for (int i = 0; i < n_cells; i++)
        begin
            if (i == pause_at)
            begin
                drain_points();
                // a write to a spare index must leave the frame running
                if ($urandom_range(1) == 1)
                    write_register(CFG_IDX_W'($urandom_range(int'(REG_FRAME_ROWS) + 1,
                                                             (1 << CFG_IDX_W) - 1)),
                                   CFG_DATA_W'($urandom));
            end
            case (pattern)
                PAT_UNIFORM: h = HEIGHT_W'($urandom_range(15));
                PAT_NARROW:  h = HEIGHT_W'(base + int'($urandom_range(2)));
                PAT_CHECKER:
                begin
                    if (((i / cols) + (i % cols)) % 2 == 1)
                        h = HEIGHT_W'($urandom_range(15, 8));
                    else
                        h = HEIGHT_W'($urandom_range(7));
                end
                default:     h = ($urandom_range(1) == 1) ? 4'hF : 4'h0;
            endcase
            send_height(h);
        end
    endtask

    initial
    begin
        int                    phase_items;
        int                    kind;
        int                    which;
        int                    new_cols;
        int                    new_rows;
        int                    cols;
        int                    rows;
        int                    n_frames;
        int                    n_cells;
        logic [CFG_DATA_W-1:0] cols_word;
        logic [CFG_DATA_W-1:0] rows_word;

        heights_ch.valid  = 1'b0;
        heights_ch.height = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        src_idle_pct      = 16;
        snk_idle_pct      = 88;
        phase_items       = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // a few cells under the reset frame size
        send_height_digits(64'hF09, 3);
        drain_points();

        // 3 x 3 with junk in the upper data bits: corner minima, then ties
        write_register(REG_FRAME_COLS, 16'hFF03);
        write_register(REG_FRAME_ROWS, 16'hF803);
        send_height_digits(64'h050_5F5_050, 9);
        send_height_digits(64'h733_F8F_FFE, 9);
        drain_points();

        // sizes below the minimum clamp to 2 x 2
        write_register(REG_FRAME_COLS, 16'h0001);
        write_register(REG_FRAME_ROWS, 16'h0000);
        send_height_digits(64'h0FF0, 4);
        drain_points();

        // widest frame, with a pause part way
        write_register(REG_FRAME_COLS, 16'h00FF);
        write_register(REG_FRAME_ROWS, 16'h0002);
        send_cells(256, N_COLS, PAT_UNIFORM, 100);
        drain_points();

        // narrowest and tallest frame, first rows only, dense in low points
        write_register(REG_FRAME_COLS, 16'h0700);
        write_register(REG_FRAME_ROWS, 16'hFFFF);
        send_cells(TALL_CELLS, 2, PAT_CHECKER, -1);

        // random phases: sender light and receiver heavy, then swapped, then free running
        for (int phase = 0; phase < 3; phase++)
        begin
            drain_points();
            if (phase == 0)
            begin
                src_idle_pct = 16;
                snk_idle_pct = 88;
            end
            else if (phase == 1)
            begin
                src_idle_pct = 88;
                snk_idle_pct = 16;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            phase_items = 0;

            while (phase_items < RANDOM_ITEMS / 3)
            begin
                drain_points();

                kind = int'($urandom_range(9));
                if (kind <= 6)
                begin
                    new_cols = int'($urandom_range(8, 2));
                    new_rows = int'($urandom_range(6, 2));
                end
                else if (kind == 7)
                begin
                    new_cols = int'($urandom_range(24, 9));
                    new_rows = 2;
                end
                else
                begin
                    new_cols = int'($urandom_range(1));
                    new_rows = int'($urandom_range(4));
                end

                // kind 9 keeps the running frame going where it stopped
                if (kind != 9)
                begin
                    cols_word = CFG_DATA_W'($urandom);
                    rows_word = CFG_DATA_W'($urandom);
                    cols_word[COLS_REG_W-1:0] = COLS_REG_W'(new_cols);
                    rows_word[ROWS_REG_W-1:0] = ROWS_REG_W'(new_rows);
                    which = int'($urandom_range(9));
                    if (which == 0)
                        write_register(REG_FRAME_COLS, cols_word);
                    else if (which == 1)
                        write_register(REG_FRAME_ROWS, rows_word);
                    else if (which < 6)
                    begin
                        write_register(REG_FRAME_COLS, cols_word);
                        write_register(REG_FRAME_ROWS, rows_word);
                    end
                    else
                    begin
                        write_register(REG_FRAME_ROWS, rows_word);
                        write_register(REG_FRAME_COLS, cols_word);
                    end
                end

                points_sb.frame_shape(cols, rows);
                n_frames = int'($urandom_range(2, 1));
                for (int f = 0; f < n_frames; f++)
                begin
                    // mostly whole frames, now and then a broken one
                    if ($urandom_range(6) == 0)
                        n_cells = int'($urandom_range(cols * rows - 1, 1));
                    else
                        n_cells = cols * rows;
                    // large frames are only sent in part
                    if (n_cells > BURST_CELLS)
                        n_cells = BURST_CELLS;
                    send_cells(n_cells, cols, height_pattern_t'($urandom_range(3)),
                               ($urandom_range(3) == 0) ? int'($urandom_range(n_cells - 1)) : -1);
                    phase_items += n_cells;
                end
            end
        end

        // wind down and report
        drain_points();
        if (points_sb.mismatches == 0 && points_sb.points_outstanding() == 0)
            $display("height_map_low_point_detector_top test passed");
        else
            $display("height_map_low_point_detector_top test failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/hlpd_pkg.sv
hw/rtl/hlpd_cell_if.sv
hw/rtl/hlpd_result_if.sv
hw/rtl/hlpd_cfg_if.sv
hw/rtl/hlpd_line_store.sv
hw/rtl/hlpd_detect.sv
hw/rtl/hlpd_emit.sv
hw/rtl/height_map_low_point_detector_top.sv
tb/sv/height_map_low_point_detector_top_tb.sv
